// File: rtl/core/crcs_pkg.sv
// ----------------------------------------------------------------------------
// crcs_pkg: shared types and constants of the climate relay control core
// Field widths, the fixed-point heat index schedule, controller states and the
// command and result bundles passed between the core's modules.
// ----------------------------------------------------------------------------
package crcs_pkg;

  // Field widths
  localparam int CNT_W   = 16;   // internal heat-on counter
  localparam int HOC_W   = 16;   // heat_on_count field
  localparam int TEMP_W  = 11;
  localparam int HUM_W   = 10;
  localparam int HI_W    = 16;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 11;

  // Stream widths
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 1;

  // Polynomial datapath widths
  localparam int MA_W   = 11;    // multiplier operand a: temperature or humidity
  localparam int MB_W   = 42;    // multiplier operand b: partial sum or coefficient
  localparam int ACC_W  = 52;    // accumulator, holds the full sum
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(7);

  // Rounding: divide by 1000 * 2^24 as a shift followed by a reciprocal multiply
  localparam int RND_SHIFT   = 24;
  localparam int X_W         = ACC_W - RND_SHIFT;
  localparam int XQ_W        = 25;
  localparam int RECIP_W     = 26;
  localparam int RECIP_SHIFT = 35;
  localparam int QPROD_W     = XQ_W + RECIP_W;
  localparam logic [ACC_W-1:0]   HALF_DIV = ACC_W'(64'd8388608000);
  localparam logic [X_W-1:0]     SAT_X    = X_W'(32'd32768000);
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(32'd34359739);
  localparam logic signed [HI_W-1:0] HI_MAX = 16'sh7FFF;
  localparam logic signed [HI_W-1:0] HI_MIN = 16'sh8000;

  // Scaled Q8.24 coefficients
  localparam logic signed [ACC_W-1:0] K1 = ACC_W'(-64'sd1473827210000);
  localparam logic signed [ACC_W-1:0] K2 = ACC_W'(64'sd27034707000);
  localparam logic signed [ACC_W-1:0] K3 = ACC_W'(64'sd39234339000);
  localparam logic signed [ACC_W-1:0] K4 = ACC_W'(-64'sd245142100);
  localparam logic signed [MB_W-1:0]  K5 = MB_W'(-64'sd20649600);
  localparam logic signed [ACC_W-1:0] K6 = ACC_W'(-64'sd27556300);
  localparam logic signed [MB_W-1:0]  K7 = MB_W'(64'sd371070);
  localparam logic signed [ACC_W-1:0] K8 = ACC_W'(64'sd121710);
  localparam logic signed [MB_W-1:0]  K9 = MB_W'(-64'sd60);

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    CFG_HEAT_ON   = 2'd0,
    CFG_HEAT_OFF  = 2'd1,
    CFG_HUMID_ON  = 2'd2,
    CFG_HUMID_OFF = 2'd3
  } cfg_idx_t;

  typedef enum logic {A_TEMP, A_HUM} asel_t;
  typedef enum logic [1:0] {B_ACC, B_HOLD, B_CONST} bsel_t;

  // One multiply-add step: dst = a * b + addend
  typedef struct packed {
    asel_t                    a_sel;
    bsel_t                    b_sel;
    logic                     add_acc;   // addend is the accumulator
    logic                     to_hold;   // result goes to the hold register
    logic signed [MB_W-1:0]   kmul;
    logic signed [ACC_W-1:0]  kadd;
  } step_t;

  // S = g0 + h*(g1 + h*g2), each g evaluated by Horner in t
  function automatic step_t step_info(input logic [STEP_W-1:0] idx);
    step_t s;
    s = '{a_sel: A_TEMP, b_sel: B_CONST, add_acc: 1'b0, to_hold: 1'b0,
          kmul: K9, kadd: K8};
    unique case (idx)
      3'd0: s = '{A_TEMP, B_CONST, 1'b0, 1'b0, K9, K8};
      3'd1: s = '{A_TEMP, B_ACC,   1'b0, 1'b1, K9, K6};   // g2
      3'd2: s = '{A_TEMP, B_CONST, 1'b0, 1'b0, K7, K4};
      3'd3: s = '{A_TEMP, B_ACC,   1'b0, 1'b0, K7, K3};   // g1
      3'd4: s = '{A_HUM,  B_HOLD,  1'b1, 1'b1, K7, K3};   // g1 + h*g2
      3'd5: s = '{A_TEMP, B_CONST, 1'b0, 1'b0, K5, K2};
      3'd6: s = '{A_TEMP, B_ACC,   1'b0, 1'b0, K5, K1};   // g0
      3'd7: s = '{A_HUM,  B_HOLD,  1'b1, 1'b0, K5, K1};   // full sum
      default: ;
    endcase
    return s;
  endfunction

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_RND, ST_QMUL, ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              ready;
    logic              start;
    logic              mul;
    logic              add;
    logic              rnd;
    logic              qmul;
    logic              load;
    logic [STEP_W-1:0] step;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic                   heater;
    logic                   humid;
    logic [HOC_W-1:0]       count;
    logic signed [HI_W-1:0] hi;
    logic                   hi_valid;
  } result_t;

endpackage

// File: rtl/core/crcs_ctrl.sv
// ----------------------------------------------------------------------------
// crcs_ctrl: sequencer of the climate relay control core
// Accepts one item, walks the eight multiply-add steps, the rounding and the
// reciprocal multiply, then hands the result to the output register.
// ----------------------------------------------------------------------------
module crcs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_free,
  output crcs_pkg::cmd_t cmd
);
  import crcs_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  // State and step registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_RND;
        end else begin
          step_nxt  = step_r + STEP_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_QMUL;
      end
      ST_QMUL: begin
        cmd.qmul  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/crcs_dpath.sv
// ----------------------------------------------------------------------------
// crcs_dpath: datapath of the climate relay control core
// Threshold registers, relay hysteresis, heat-on counter, the shared
// multiplier that evaluates the heat index polynomial, and its rounding.
// ----------------------------------------------------------------------------
module crcs_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [crcs_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [crcs_pkg::CFG_DW-1:0]      cfg_wdata,
  input  logic [crcs_pkg::IN_DATA_W-1:0]   in_data,
  input  logic [crcs_pkg::IN_USER_W-1:0]   in_user,
  input  crcs_pkg::cmd_t                   cmd,
  output crcs_pkg::result_t                res
);
  import crcs_pkg::*;

  // Thresholds
  logic signed [TEMP_W-1:0] heat_on_r, heat_off_r;
  logic [HUM_W-1:0]         humid_on_r, humid_off_r;

  // Control state
  logic             heater_r, heater_nxt;
  logic             humid_r, humid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Item operands
  logic signed [TEMP_W-1:0] in_temp;
  logic [HUM_W-1:0]         in_hum;
  logic                     in_tv, in_hv;
  logic signed [MA_W-1:0]   t_r, h_r;
  logic                     both_r;

  // Polynomial datapath
  step_t                       st;
  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [MA_W+MB_W-1:0] prod_full;
  logic signed [ACC_W-1:0]     prod_r, acc_r, addend, sum;
  logic signed [MB_W-1:0]      hold_r;

  // Rounding and scaling
  logic                   neg, neg_r, sat_r;
  logic [ACC_W-1:0]       mag, rsum;
  logic [X_W-1:0]         xval;
  logic [XQ_W-1:0]        x_r;
  logic [QPROD_W-1:0]     qprod;
  logic [HI_W-1:0]        q_r;
  logic signed [HI_W-1:0] hi_val;

  assign in_temp = in_data[TEMP_W-1:0];
  assign in_hum  = in_data[TEMP_W +: HUM_W];
  assign in_tv   = in_user[0];
  assign in_hv   = in_user[1];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_on_r   <= TEMP_W'(200);
      heat_off_r  <= TEMP_W'(220);
      humid_on_r  <= HUM_W'(500);
      humid_off_r <= HUM_W'(600);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_HEAT_ON:   heat_on_r   <= cfg_wdata[TEMP_W-1:0];
        CFG_HEAT_OFF:  heat_off_r  <= cfg_wdata[TEMP_W-1:0];
        CFG_HUMID_ON:  humid_on_r  <= cfg_wdata[HUM_W-1:0];
        CFG_HUMID_OFF: humid_off_r <= cfg_wdata[HUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Hysteresis and counter update for an accepted item
  always_comb begin
    heater_nxt = heater_r;
    humid_nxt  = humid_r;
    count_nxt  = heater_r ? count_r + CNT_W'(1) : count_r;
    if (in_tv) begin
      if (heater_r) begin
        if (in_temp >= heat_off_r) heater_nxt = 1'b0;
      end else if (in_temp <= heat_on_r) begin
        heater_nxt = 1'b1;
      end
    end
    if (in_hv) begin
      if (humid_r) begin
        if (in_hum >= humid_off_r) humid_nxt = 1'b0;
      end else if (in_hum <= humid_on_r) begin
        humid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heater_r <= 1'b0;
      humid_r  <= 1'b0;
      count_r  <= '0;
    end else if (cmd.start) begin
      heater_r <= heater_nxt;
      humid_r  <= humid_nxt;
      count_r  <= count_nxt;
    end
  end

  // Operand capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t_r    <= in_temp;
      h_r    <= {1'b0, in_hum};
      both_r <= in_tv & in_hv;
    end
  end

  // Shared multiplier, one step as a multiply state and an add state
  assign st    = step_info(cmd.step);
  assign mul_a = (st.a_sel == A_HUM) ? h_r : t_r;

  always_comb begin
    unique case (st.b_sel)
      B_ACC:   mul_b = acc_r[MB_W-1:0];
      B_HOLD:  mul_b = hold_r;
      B_CONST: mul_b = st.kmul;
      default: mul_b = st.kmul;
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign addend    = st.add_acc ? acc_r : st.kadd;
  assign sum       = prod_r + addend;

  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= prod_full[ACC_W-1:0];
    if (cmd.add) begin
      if (st.to_hold) hold_r <= sum[MB_W-1:0];
      else            acc_r  <= sum;
    end
  end

  // Round to nearest, ties away from zero: (|S| + D/2) >> 24, then / 1000
  assign neg  = acc_r[ACC_W-1];
  assign mag  = neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign rsum = mag + HALF_DIV;
  assign xval = rsum[ACC_W-1:RND_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      neg_r <= neg;
      sat_r <= (xval >= SAT_X);
      x_r   <= xval[XQ_W-1:0];
    end
  end

  // Divide by 1000 through the reciprocal
  assign qprod = x_r * RECIP;

  always_ff @(posedge clk) begin
    if (cmd.qmul) q_r <= qprod[QPROD_W-1:RECIP_SHIFT];
  end

  // Result fields
  always_comb begin
    if (!both_r)     hi_val = '0;
    else if (sat_r)  hi_val = neg_r ? HI_MIN : HI_MAX;
    else if (neg_r)  hi_val = -$signed(q_r);
    else             hi_val = $signed(q_r);
  end

  assign res.heater   = heater_r;
  assign res.humid    = humid_r;
  assign res.count    = HOC_W'(count_r);
  assign res.hi       = hi_val;
  assign res.hi_valid = both_r;

endmodule

// File: rtl/core/climate_relay_control_step_core.sv
// ----------------------------------------------------------------------------
// climate_relay_control_step_core: thermostat and humidistat relay step
// One sensor reading in, one relay and heat index result out.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream in_*: one item per sensor reading. Output stream out_*: one
//   item per reading with both relay states, the heat-on count and the heat
//   index in tenths of a degree.
//   Configuration: thresholds are written through cfg_we/cfg_addr/cfg_wdata
//   while no item is in flight; a write takes effect at the next clock edge.
//   Sequence: once an input item is accepted, the heat index polynomial runs
//   as eight multiply-add steps, each a multiply state and an add state, on
//   one shared 11 x 42 bit multiplier, followed by a rounding step, a
//   reciprocal multiply for the divide by 1000 and a hand-over to the output
//   register; the hand-over waits while that register is still occupied.
//   Flow: a new item is accepted only once the previous result has been
//   handed over; the next item is accepted while a finished result still
//   waits in the output register.
//   Reset: relays off, heat-on count zero, thresholds at their defaults.
//   Stall: when out_tready is low the result holds in the output register;
//   a further finished result waits in the datapath and in_tready stays low.
// ----------------------------------------------------------------------------
module climate_relay_control_step_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration
  input  logic                               cfg_we,
  input  logic [crcs_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [crcs_pkg::CFG_DW-1:0]        cfg_wdata,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [crcs_pkg::IN_DATA_W-1:0]     in_tdata,   // temp_tenths, humid_tenths
  input  logic [crcs_pkg::IN_USER_W-1:0]     in_tuser,   // temp_valid, humid_valid
  // Output stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [crcs_pkg::OUT_DATA_W-1:0]    out_tdata,  // heater_relay, humidifier_relay,
                                                         // heat_on_count, heat_index_tenths
  output logic [crcs_pkg::OUT_USER_W-1:0]    out_tuser   // heat_index_valid
);
  import crcs_pkg::*;

  cmd_t                  cmd;
  result_t               res;
  logic                  out_free;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = cmd.ready;

  crcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .cmd      (cmd)
  );

  crcs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_tdata),
    .in_user   (in_tuser),
    .cmd       (cmd),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= {6'b0, res.hi, res.count, res.humid, res.heater};
      out_user_r <= res.hi_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef NO_ASSERTIONS
  // A hand-over always leaves a valid result behind
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("result lost at hand-over");

  // No hand-over while the output register is still occupied
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  // An invalid heat index is reported as zero
  a_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_user_r[0]) |-> (out_data_r[33:18] == '0))
    else $error("heat index not zero while invalid");

  // The counter steps once for each reading taken with the heater on
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && res.heater) |=>
      (res.count == $past(res.count) + HOC_W'(1)))
    else $error("heat-on counter did not advance");
`endif

endmodule

// File: tb/sv/tb_climate_relay_control_step_core.sv
// ----------------------------------------------------------------------------
// tb_climate_relay_control_step_core: self-checking bench for the relay step
// Readings stream in through a queue-fed driver and results are checked by a
// clocked monitor against an in-bench model of the thermostat, humidistat,
// heat-on counter and fixed-point heat index. The run walks through several
// threshold settings, from the reset defaults to full-width extremes and
// inverted levels, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb_climate_relay_control_step_core;
  timeunit 1ns;
  timeprecision 1ps;

  import crcs_pkg::*;

  // One sensor reading as the bench sees it
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic                     temp_ok;
    logic [HUM_W-1:0]         humid;
    logic                     humid_ok;
  } reading_t;

  // Bit positions inside out_tdata
  localparam int CNT_LO = 2;
  localparam int HI_LO  = CNT_LO + HOC_W;

  // Heat index coefficients, Q8.24
  localparam longint HQ1 = -147382721;
  localparam longint HQ2 = 27034707;
  localparam longint HQ3 = 39234339;
  localparam longint HQ4 = -2451421;
  localparam longint HQ5 = -206496;
  localparam longint HQ6 = -275563;
  localparam longint HQ7 = 37107;
  localparam longint HQ8 = 12171;
  localparam longint HQ9 = -60;
  localparam longint HI_DIV = 64'd16777216000;   // 1000 * 2^24

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_AW-1:0]     cfg_addr;
  logic [CFG_DW-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // temp_tenths, humid_tenths
  logic [IN_USER_W-1:0]  in_tuser;    // temp_valid, humid_valid
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // heater_relay, humidifier_relay,
                                      // heat_on_count, heat_index_tenths
  logic [OUT_USER_W-1:0] out_tuser;   // heat_index_valid

  climate_relay_control_step_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model copy of the levels and the controller state
  logic signed [TEMP_W-1:0] heat_on_lvl  = 11'sd200;
  logic signed [TEMP_W-1:0] heat_off_lvl = 11'sd220;
  logic [HUM_W-1:0]         humid_on_lvl  = 10'd500;
  logic [HUM_W-1:0]         humid_off_lvl = 10'd600;
  logic                     heater_on     = 1'b0;
  logic                     humidifier_on = 1'b0;
  logic [CNT_W-1:0]         heat_count    = '0;

  reading_t readings_to_send[$];
  result_t  expected_results[$];

  bit idle_on;
  bit in_taken;
  int in_gap;
  int out_stall;

  int n_mismatch;
  int n_checked;
  int n_readings;
  int n_settings;
  int n_both_ok;
  int n_rail;
  int n_heater_switch;
  int n_humid_switch;

  // Heat index in tenths: exact sum, divide with ties away from zero, saturate
  function automatic logic signed [HI_W-1:0] heat_index_of(longint t, longint h);
    longint s;
    longint mag;
    longint q;
    s = HQ1 * 10000 + HQ2 * t * 1000 + HQ3 * h * 1000
      + HQ4 * t * h * 100 + HQ5 * t * t * 100 + HQ6 * h * h * 100
      + HQ7 * t * t * h * 10 + HQ8 * t * h * h * 10 + HQ9 * t * t * h * h;
    mag = (s < 0) ? -s : s;
    q = (mag + HI_DIV / 2) / HI_DIV;
    if (s < 0)
      return (q > 32768) ? 16'sh8000 : HI_W'(-q);
    return (q > 32767) ? 16'sh7FFF : HI_W'(q);
  endfunction

  // One controller step: count, hysteresis on both relays, heat index
  function automatic result_t climate_step(reading_t r);
    result_t res;
    logic    was_heater;
    logic    was_humid;
    was_heater = heater_on;
    was_humid  = humidifier_on;
    if (heater_on)
      heat_count = heat_count + 1'b1;
    if (r.temp_ok) begin
      if (heater_on) begin
        if (r.temp >= heat_off_lvl)
          heater_on = 1'b0;
      end else if (r.temp <= heat_on_lvl) begin
        heater_on = 1'b1;
      end
    end
    if (r.humid_ok) begin
      if (humidifier_on) begin
        if (r.humid >= humid_off_lvl)
          humidifier_on = 1'b0;
      end else if (r.humid <= humid_on_lvl) begin
        humidifier_on = 1'b1;
      end
    end
    if (heater_on != was_heater)
      n_heater_switch++;
    if (humidifier_on != was_humid)
      n_humid_switch++;
    res.heater   = heater_on;
    res.humid    = humidifier_on;
    res.count    = heat_count;
    res.hi_valid = r.temp_ok && r.humid_ok;
    res.hi       = res.hi_valid ? heat_index_of(r.temp, r.humid) : '0;
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    n_mismatch++;
    if (n_mismatch <= 30)
      $display("MISMATCH result %0d %s: got %0d expected %0d",
               n_checked, field, got, want);
  endtask

  // Input driver: next reading once the current one is taken
  always @(negedge clk) begin : reading_driver
    reading_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (readings_to_send.size() > 0) begin
        r = readings_to_send.pop_front();
        in_tdata  <= IN_DATA_W'({r.humid, r.temp});
        in_tuser  <= {r.humid_ok, r.temp_ok};
        in_tvalid <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0)
          in_gap <= $urandom_range(1, 7);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in bursts
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: check results, predict on every accepted reading
  always @(posedge clk) begin : result_monitor
    result_t  got;
    result_t  want;
    reading_t r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.heater   = out_tdata[0];
        got.humid    = out_tdata[1];
        got.count    = out_tdata[CNT_LO +: HOC_W];
        got.hi       = out_tdata[HI_LO +: HI_W];
        got.hi_valid = out_tuser[0];
        n_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.heater !== want.heater)
            report_mismatch("heater_relay", got.heater, want.heater);
          if (got.humid !== want.humid)
            report_mismatch("humidifier_relay", got.humid, want.humid);
          if (got.count !== want.count)
            report_mismatch("heat_on_count", got.count, want.count);
          if (got.hi !== want.hi)
            report_mismatch("heat_index_tenths", longint'(got.hi), longint'(want.hi));
          if (got.hi_valid !== want.hi_valid)
            report_mismatch("heat_index_valid", got.hi_valid, want.hi_valid);
        end
      end
      if (in_tvalid && in_tready) begin
        r.temp     = in_tdata[TEMP_W-1:0];
        r.humid    = in_tdata[TEMP_W +: HUM_W];
        r.temp_ok  = in_tuser[0];
        r.humid_ok = in_tuser[1];
        want = climate_step(r);
        expected_results.push_back(want);
        n_readings++;
        if (want.hi_valid) begin
          n_both_ok++;
          if (want.hi == 16'sh7FFF || want.hi == 16'sh8000)
            n_rail++;
        end
      end
    end
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // Stimulus helpers
  task automatic add_reading(int t, bit tv, int h, bit hv);
    reading_t r;
    r.temp     = TEMP_W'(t);
    r.temp_ok  = tv;
    r.humid    = HUM_W'(h);
    r.humid_ok = hv;
    readings_to_send.push_back(r);
  endtask

  function automatic logic signed [TEMP_W-1:0] near_temp();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'(heat_on_lvl) + int'($urandom_range(0, 6)) - 3;
      1: v = int'(heat_off_lvl) + int'($urandom_range(0, 6)) - 3;
      2: v = int'($urandom_range(0, 1200)) - 400;
      default: v = int'(heat_on_lvl) + int'($urandom_range(0, 80)) - 40;
    endcase
    if (v < -1024)
      v = -1024;
    if (v > 1023)
      v = 1023;
    return TEMP_W'(v);
  endfunction

  function automatic logic [HUM_W-1:0] near_humid();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'(humid_on_lvl) + int'($urandom_range(0, 6)) - 3;
      1: v = int'(humid_off_lvl) + int'($urandom_range(0, 6)) - 3;
      2: v = int'($urandom_range(0, 1000));
      default: v = int'(humid_on_lvl) + int'($urandom_range(0, 80)) - 40;
    endcase
    if (v < 0)
      v = 0;
    if (v > 1023)
      v = 1023;
    return HUM_W'(v);
  endfunction

  // Mostly readings around the current levels, some raw bit patterns
  task automatic add_random_readings(int n);
    reading_t r;
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        r.temp     = TEMP_W'($urandom);
        r.humid    = HUM_W'($urandom);
        r.temp_ok  = 1'($urandom);
        r.humid_ok = 1'($urandom);
      end else begin
        r.temp     = near_temp();
        r.humid    = near_humid();
        r.temp_ok  = ($urandom_range(0, 11) != 0);
        r.humid_ok = ($urandom_range(0, 11) != 0);
      end
      readings_to_send.push_back(r);
    end
  endtask

  task automatic wait_idle();
    while (readings_to_send.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_level(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DW'(val);
    case (idx)
      CFG_HEAT_ON:   heat_on_lvl   = TEMP_W'(val);
      CFG_HEAT_OFF:  heat_off_lvl  = TEMP_W'(val);
      CFG_HUMID_ON:  humid_on_lvl  = HUM_W'(val);
      CFG_HUMID_OFF: humid_off_lvl = HUM_W'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_levels(int t_on, int t_off, int h_on, int h_off);
    wait_idle();
    write_level(CFG_HEAT_ON, t_on);
    write_level(CFG_HEAT_OFF, t_off);
    write_level(CFG_HUMID_ON, h_on);
    write_level(CFG_HUMID_OFF, h_off);
    n_settings++;
  endtask

  // Run limit
  initial begin
    #4_000_000;
    $display("tb_climate_relay_control_step_core failed");
    $finish;
  end

  initial begin : sequence_main
    int t_on;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    idle_on    = 1'b1;
    n_settings = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed readings at the reset levels (on 200/500, off 220/600)
    add_reading(-1024, 1, 0, 1);       // both relays on, lowest inputs
    add_reading(219, 1, 599, 1);       // just under off levels: stay on
    add_reading(220, 1, 600, 1);       // exactly off levels: both off
    add_reading(201, 1, 501, 1);       // just above on levels: stay off
    add_reading(200, 1, 500, 1);       // exactly on levels: both on
    add_reading(1023, 0, 1023, 1);     // temp invalid: heater kept on
    add_reading(1023, 1, 0, 0);        // humid invalid: humidifier kept
    add_reading(-400, 0, 0, 0);        // both invalid: both relays kept off
    add_reading(1023, 1, 1023, 1);     // both inputs at the top of their range
    add_reading(-1024, 1, 1023, 1);
    add_reading(1023, 1, 0, 1);
    add_reading(-400, 1, 0, 1);        // negative heat index
    add_reading(800, 1, 1000, 1);
    add_reading(0, 1, 0, 1);
    add_reading(-1, 1, 1, 1);
    add_reading(11'h555, 1, 10'h2AA, 1);
    add_reading(11'h2AA, 1, 10'h155, 1);
    add_reading(333, 1, 555, 1);
    add_reading(250, 1, 650, 1);

    // Level settings: full-width extremes, inverted, range limits, random
    set_levels(-1024, 1023, 0, 1023);
    add_random_readings(150);
    set_levels(1023, -1024, 1023, 0);
    idle_on = 1'b0;
    add_random_readings(150);
    set_levels(-400, 800, 0, 1000);
    idle_on = 1'b1;
    add_random_readings(150);
    set_levels(800, -400, 1000, 0);
    add_random_readings(150);
    repeat (4) begin
      t_on = int'($urandom_range(0, 1200)) - 400;
      set_levels(t_on, t_on + int'($urandom_range(0, 60)),
                 int'($urandom_range(0, 900)), int'($urandom_range(0, 1023)));
      idle_on = ($urandom_range(0, 3) != 0);
      add_random_readings(150);
    end

    // Last stretch at the defaults, streams at full rate
    set_levels(200, 220, 500, 600);
    idle_on = 1'b0;
    add_random_readings(150);

    wait_idle();
    repeat (40) @(posedge clk);

    $display("%0d readings, %0d results checked over %0d level settings",
             n_readings, n_checked, n_settings);
    $display("%0d heat index values (%0d on a rail), %0d heater / %0d humidifier switches",
             n_both_ok, n_rail, n_heater_switch, n_humid_switch);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("tb_climate_relay_control_step_core passed");
    end else begin
      $display("tb_climate_relay_control_step_core failed");
    end
    $finish;
  end

endmodule
